// ===== design/vector_to_binary_angle_assert.svh =====
// Assertion macros shared by the checker of vector_to_binary_angle.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef VECTOR_TO_BINARY_ANGLE_ASSERT_SVH
`define VECTOR_TO_BINARY_ANGLE_ASSERT_SVH

// checked only while out of reset
`define VTBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define VTBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/vtba_pkg.sv =====
// Package for vector_to_binary_angle: item types, pipeline record and the
// sin/cos step table (Q2.62) built at elaboration. No dependencies.
package vtba_pkg;

  localparam int COORD_W      = 16;
  localparam int MAG_W        = COORD_W;   // magnitude of -2^(W-1) still fits unsigned
  localparam int HEAD_W       = 8;
  localparam int K_W          = 6;         // in-quadrant step index, 0..63
  localparam int SEARCH_STEPS = K_W;
  localparam int HALF_W       = 32;        // coefficient split for the multipliers
  localparam int PROD_W       = MAG_W + HALF_W;
  localparam int CMP_W        = MAG_W + 2 * HALF_W;

  localparam logic [HEAD_W-1:0] HEAD_N = 8'd0;
  localparam logic [HEAD_W-1:0] HEAD_E = 8'd64;
  localparam logic [HEAD_W-1:0] HEAD_S = 8'd128;
  localparam logic [HEAD_W-1:0] HEAD_W_DIR = 8'd192;

  localparam logic [K_W-1:0] K_DIAG = 6'd32;

  localparam logic [63:0] QUARTER_PI_Q64 = 64'hC90F_DAA2_2168_C234;
  localparam logic [63:0] ONE_Q62        = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
  } in_item_t;

  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              valid_res;
  } out_item_t;

  // one item in flight through the search cells
  typedef struct packed {
    logic [MAG_W-1:0]  a;        // magnitude across the quadrant start axis
    logic [MAG_W-1:0]  b;        // magnitude along it
    logic [HEAD_W-1:0] heading;  // base in the top bits, search bits below
    logic              direct;   // axis or zero vector, heading already final
    logic              nz;
  } pipe_t;

  typedef struct packed {
    logic [63:0] c;
    logic [63:0] s;
  } sc_pair_t;

  typedef sc_pair_t [63:0] sc_tab_t;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] div_sin_term(input logic [63:0] t, input int n);
    logic [63:0] q;
    case (n)
      1:       q = t / 64'd6;
      2:       q = t / 64'd20;
      3:       q = t / 64'd42;
      4:       q = t / 64'd72;
      5:       q = t / 64'd110;
      6:       q = t / 64'd156;
      7:       q = t / 64'd210;
      8:       q = t / 64'd272;
      9:       q = t / 64'd342;
      10:      q = t / 64'd420;
      11:      q = t / 64'd506;
      12:      q = t / 64'd600;
      default: q = '0;
    endcase
    return q;
  endfunction

  function automatic logic [63:0] div_cos_term(input logic [63:0] t, input int n);
    logic [63:0] q;
    case (n)
      1:       q = t / 64'd2;
      2:       q = t / 64'd12;
      3:       q = t / 64'd30;
      4:       q = t / 64'd56;
      5:       q = t / 64'd90;
      6:       q = t / 64'd132;
      7:       q = t / 64'd182;
      8:       q = t / 64'd240;
      9:       q = t / 64'd306;
      10:      q = t / 64'd380;
      11:      q = t / 64'd462;
      12:      q = t / 64'd552;
      default: q = '0;
    endcase
    return q;
  endfunction

  // sin and cos of j*pi/128 by truncated Taylor series
  function automatic sc_pair_t step_sincos(input logic [K_W-1:0] j);
    logic [127:0] p;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  t;
    logic [63:0]  sum;
    sc_pair_t     r;
    p  = {64'd0, 58'd0, j} * {64'd0, QUARTER_PI_Q64};
    x  = p[70:7];
    x2 = mul_q62(x, x);
    sum = x;
    t   = x;
    for (int n = 1; n <= 12; n++) begin
      t   = div_sin_term(mul_q62(t, x2), n);
      sum = (n % 2 == 1) ? sum - t : sum + t;
    end
    r.s = sum;
    sum = ONE_Q62;
    t   = ONE_Q62;
    for (int n = 1; n <= 12; n++) begin
      t   = div_cos_term(mul_q62(t, x2), n);
      sum = (n % 2 == 1) ? sum - t : sum + t;
    end
    r.c = sum;
    return r;
  endfunction

  function automatic sc_tab_t build_sc_tab();
    sc_tab_t  tab;
    sc_pair_t tmp;
    for (int k = 0; k < 64; k++) begin
      if (k >= 1 && k <= 31) begin
        tab[k] = step_sincos(K_W'(k));
      end else if (k >= 33) begin
        tmp      = step_sincos(K_W'(64 - k));
        tab[k].c = tmp.s;
        tab[k].s = tmp.c;
      end else begin
        tab[k] = '0;
      end
    end
    return tab;
  endfunction

  localparam sc_tab_t SC_TAB = build_sc_tab();

endpackage

// ===== design/vector_to_binary_angle.sv =====
// Top level of vector_to_binary_angle: front stage and six search cells.
// Depends on vtba_pkg, vtba_front and vtba_cell.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries a signed displacement
//   (dx, dy). Result channel out_valid/out_ready/out_data carries the
//   heading on a 256-step circle (0 toward +y, 64 toward +x, clockwise)
//   and valid_res, which is 0 with heading 0 for the zero vector.
//   Thirteen register stages (one fold stage, then two per cell for six
//   cells, one heading bit each), the first loaded at the accepting edge
//   itself; out_valid comes from the last of them.
//   Throughput: one item per cycle while out_ready is high; every stage is a
//   handshaked register, so items follow each other back to back.
//   Stall: when out_ready is low the result holds; stages behind it keep
//   filling empty slots, and in_ready falls only once the chain is full.
//   Reset (rst_n low, synchronous) drops every item in flight; in_ready is
//   high in the cycle after reset ends.
module vector_to_binary_angle (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vtba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vtba_pkg::out_item_t out_data
);
  import vtba_pkg::*;

  logic  [SEARCH_STEPS:0] cv;
  logic  [SEARCH_STEPS:0] cr;
  pipe_t                  cd [SEARCH_STEPS+1];

  vtba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cd[0])
  );

  for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_cell
    vtba_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cd[i+1])
    );
  end

  assign cr[SEARCH_STEPS]   = out_ready;
  assign out_valid          = cv[SEARCH_STEPS];
  assign out_data.heading   = cd[SEARCH_STEPS].heading;
  assign out_data.valid_res = cd[SEARCH_STEPS].nz;

endmodule

// ===== design/vtba_front.sv =====
// Input stage of vector_to_binary_angle: sign split, axis cases and
// quadrant fold into one registered pipe_t. Uses vtba_pkg.
module vtba_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vtba_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vtba_pkg::pipe_t   out_data
);
  import vtba_pkg::*;

  logic             valid_r;
  pipe_t            data_r;
  pipe_t            data_nxt;
  logic [MAG_W-1:0] ux;
  logic [MAG_W-1:0] uy;
  logic [MAG_W-1:0] ax;
  logic [MAG_W-1:0] ay;
  logic             nx;
  logic             ny;

  assign ux = in_data.dx;
  assign uy = in_data.dy;
  assign nx = ux[MAG_W-1];
  assign ny = uy[MAG_W-1];
  assign ax = nx ? (~ux + 1'b1) : ux;
  assign ay = ny ? (~uy + 1'b1) : uy;

  always_comb begin
    data_nxt        = '0;
    data_nxt.nz     = 1'b1;
    if (ax == '0 && ay == '0) begin
      data_nxt.direct  = 1'b1;
      data_nxt.nz      = 1'b0;
      data_nxt.heading = HEAD_N;
    end else if (ax == '0) begin
      data_nxt.direct  = 1'b1;
      data_nxt.heading = ny ? HEAD_S : HEAD_N;
    end else if (ay == '0) begin
      data_nxt.direct  = 1'b1;
      data_nxt.heading = nx ? HEAD_W_DIR : HEAD_E;
    end else if (!nx && !ny) begin
      data_nxt.a       = ax;
      data_nxt.b       = ay;
      data_nxt.heading = HEAD_N;
    end else if (!nx && ny) begin
      data_nxt.a       = ay;
      data_nxt.b       = ax;
      data_nxt.heading = HEAD_E;
    end else if (nx && ny) begin
      data_nxt.a       = ax;
      data_nxt.b       = ay;
      data_nxt.heading = HEAD_S;
    end else begin
      data_nxt.a       = ay;
      data_nxt.b       = ax;
      data_nxt.heading = HEAD_W_DIR;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/vtba_cell.sv =====
// One binary-search cell of vector_to_binary_angle: decides one heading bit
// by comparing a*cos(k) against b*sin(k). Two register stages. Uses vtba_pkg.
module vtba_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  vtba_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output vtba_pkg::pipe_t out_data
);
  import vtba_pkg::*;

  localparam int            BIT   = SEARCH_STEPS - 1 - STEP;
  localparam logic [K_W-1:0] PROBE = K_W'(1) << BIT;

  logic              a_rdy;
  logic              b_rdy;
  logic [K_W-1:0]    k;
  sc_pair_t          coef;

  // stage A: partial products
  logic              a_valid_r;
  pipe_t             a_data_r;
  logic              a_diag_r;
  logic [PROD_W-1:0] pa_hi_r;
  logic [PROD_W-1:0] pa_lo_r;
  logic [PROD_W-1:0] pb_hi_r;
  logic [PROD_W-1:0] pb_lo_r;

  // stage B: compare and set the bit
  logic              b_valid_r;
  pipe_t             b_data_r;
  pipe_t             b_data_nxt;
  logic [CMP_W-1:0]  lhs;
  logic [CMP_W-1:0]  rhs;
  logic              ge;
  logic              take;

  assign k    = in_data.heading[K_W-1:0] | PROBE;
  assign coef = SC_TAB[k];

  assign b_rdy    = !b_valid_r || out_ready;
  assign a_rdy    = !a_valid_r || b_rdy;
  assign in_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_rdy) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_data_r <= in_data;
      a_diag_r <= (k == K_DIAG);
      pa_hi_r  <= {{HALF_W{1'b0}}, in_data.a} * {{MAG_W{1'b0}}, coef.c[63:HALF_W]};
      pa_lo_r  <= {{HALF_W{1'b0}}, in_data.a} * {{MAG_W{1'b0}}, coef.c[HALF_W-1:0]};
      pb_hi_r  <= {{HALF_W{1'b0}}, in_data.b} * {{MAG_W{1'b0}}, coef.s[63:HALF_W]};
      pb_lo_r  <= {{HALF_W{1'b0}}, in_data.b} * {{MAG_W{1'b0}}, coef.s[HALF_W-1:0]};
    end
  end

  assign lhs = {pa_hi_r, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pa_lo_r};
  assign rhs = {pb_hi_r, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pb_lo_r};
  // the diagonal step is the exact test a >= b
  assign ge   = a_diag_r ? (a_data_r.a >= a_data_r.b) : (lhs >= rhs);
  assign take = ge && !a_data_r.direct;

  always_comb begin
    b_data_nxt         = a_data_r;
    b_data_nxt.heading = a_data_r.heading
                       | {{(HEAD_W-K_W){1'b0}}, PROBE & {K_W{take}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_rdy) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

// ===== design/vtba_checker.sv =====
// Port-level checker for vector_to_binary_angle, bound to the top level.
// Depends on vtba_pkg and vector_to_binary_angle_assert.svh.
`include "vector_to_binary_angle_assert.svh"

module vtba_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input vtba_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input vtba_pkg::out_item_t out_data
);
  import vtba_pkg::*;

  logic in_seen;

  assign in_seen = in_valid;

  `VTBA_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")
  `VTBA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `VTBA_ASSERT(a_zero_heading, out_valid && !out_data.valid_res |-> out_data.heading == HEAD_N, "zero vector with nonzero heading")
  `VTBA_ASSERT(a_ready_free, (!out_valid || out_ready) |-> in_ready || !in_seen, "input blocked with free output")

endmodule

bind vector_to_binary_angle vtba_checker u_vtba_checker (.*);
